[sv/bed_pkg.sv]
// shared types, character codes and helpers for the backslash escape decoder
package bed_pkg;

	localparam int OCT_DIGITS = 3;
	localparam int HEX_DIGITS = 2;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] ESC_BYTE = 8'h1B;
	localparam logic [7:0] CASE_BIT = 8'h20;

	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_SEVEN  = 8'h37;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LB     = 8'h62;
	localparam logic [7:0] CH_LC     = 8'h63;
	localparam logic [7:0] CH_LE     = 8'h65;
	localparam logic [7:0] CH_LF     = 8'h66;
	localparam logic [7:0] CH_LN     = 8'h6E;
	localparam logic [7:0] CH_LR     = 8'h72;
	localparam logic [7:0] CH_LT     = 8'h74;
	localparam logic [7:0] CH_LV     = 8'h76;
	localparam logic [7:0] CH_LX     = 8'h78;

	localparam logic [7:0] BEL_BYTE = 8'h07;
	localparam logic [7:0] BS_BYTE  = 8'h08;
	localparam logic [7:0] FF_BYTE  = 8'h0C;
	localparam logic [7:0] LF_BYTE  = 8'h0A;
	localparam logic [7:0] CR_BYTE  = 8'h0D;
	localparam logic [7:0] TAB_BYTE = 8'h09;
	localparam logic [7:0] VT_BYTE  = 8'h0B;

	typedef enum logic [2:0] {
		M_NORMAL = 3'd0,
		M_ESC    = 3'd1,
		M_OCT    = 3'd2,
		M_HEX    = 3'd3,
		M_PCT    = 3'd4,
		M_HALT   = 3'd5
	} mode_t;

	// one queue entry: the one or two result bytes of one item
	typedef struct packed {
		logic       two;
		logic       halt;
		logic [7:0] b0;
		logic [7:0] b1;
	} entry_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} digit_t;

	function automatic logic is_oct(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_SEVEN);
	endfunction

	function automatic digit_t hex_digit(input logic [7:0] c);
		logic [7:0] lc;
		digit_t     d;
		lc = c | CASE_BIT;
		d.ok = 1'b0;
		d.val = 4'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d.ok = 1'b1;
			d.val = c[3:0];
		end else if (lc >= CH_LA && lc <= CH_LF) begin
			d.ok = 1'b1;
			d.val = 4'(lc - CH_LA + 8'd10);
		end
		return d;
	endfunction

	// ordinary text byte that is not the start of an escape or directive
	function automatic logic plain_emits(input logic [7:0] c);
		return (c != CH_BSLASH) && (c != CH_PCT);
	endfunction

	function automatic mode_t plain_mode(input logic [7:0] c);
		if (c == CH_BSLASH)
			return M_ESC;
		else if (c == CH_PCT)
			return M_PCT;
		return M_NORMAL;
	endfunction

endpackage

[sv/bed_front.sv]
// front end: decoder state machine that turns each item into a queue entry
module bed_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         ch,
	input  logic               end_mark,
	output logic               push,
	output bed_pkg::entry_t    entry
);

	bed_pkg::mode_t mode_q, mode_d;
	logic [7:0] digit_value_q, digit_value_d;
	logic [1:0] digit_count_q, digit_count_d;
	logic [1:0] n_res;

	logic [7:0]       oct_val, hex_val;
	logic [1:0]       cnt_inc;
	bed_pkg::digit_t  hd;

	assign oct_val = {digit_value_q[4:0], ch[2:0]};
	assign hd      = bed_pkg::hex_digit(ch);
	assign hex_val = {digit_value_q[3:0], hd.val};
	assign cnt_inc = digit_count_q + 2'd1;

	// next state
	always_comb begin
		mode_d = mode_q;
		digit_value_d = digit_value_q;
		digit_count_d = digit_count_q;
		if (mode_q == bed_pkg::M_HALT) begin
			mode_d = bed_pkg::M_HALT;
		end else if (end_mark) begin
			mode_d = bed_pkg::M_NORMAL;
			digit_value_d = 8'd0;
			digit_count_d = 2'd0;
		end else begin
			unique case (mode_q)
				bed_pkg::M_ESC: begin
					if (ch == bed_pkg::CH_LC) begin
						mode_d = bed_pkg::M_HALT;
					end else if (ch == bed_pkg::CH_LX) begin
						mode_d = bed_pkg::M_HEX;
						digit_value_d = 8'd0;
						digit_count_d = 2'd0;
					end else if (bed_pkg::is_oct(ch)) begin
						digit_value_d = {5'd0, ch[2:0]};
						digit_count_d = 2'd1;
						mode_d = (bed_pkg::OCT_DIGITS <= 1) ? bed_pkg::M_NORMAL
							: bed_pkg::M_OCT;
					end else begin
						mode_d = bed_pkg::M_NORMAL;
					end
				end
				bed_pkg::M_OCT: begin
					if (bed_pkg::is_oct(ch)) begin
						digit_value_d = oct_val;
						digit_count_d = cnt_inc;
						if (int'(cnt_inc) >= bed_pkg::OCT_DIGITS)
							mode_d = bed_pkg::M_NORMAL;
					end else begin
						mode_d = bed_pkg::plain_mode(ch);
					end
				end
				bed_pkg::M_HEX: begin
					if (hd.ok) begin
						digit_value_d = hex_val;
						digit_count_d = cnt_inc;
						if (int'(cnt_inc) >= bed_pkg::HEX_DIGITS)
							mode_d = bed_pkg::M_NORMAL;
					end else begin
						mode_d = bed_pkg::plain_mode(ch);
					end
				end
				bed_pkg::M_PCT: begin
					if (ch == bed_pkg::CH_PCT)
						mode_d = bed_pkg::M_NORMAL;
					else
						mode_d = bed_pkg::plain_mode(ch);
				end
				default: begin
					mode_d = bed_pkg::plain_mode(ch);
				end
			endcase
		end
	end

	// result bytes of this item
	always_comb begin
		n_res = 2'd0;
		entry.b0 = ch;
		entry.b1 = ch;
		entry.halt = 1'b0;
		if (mode_q == bed_pkg::M_HALT) begin
			n_res = 2'd0;
		end else if (end_mark) begin
			unique case (mode_q)
				bed_pkg::M_ESC: begin
					n_res = 2'd1;
					entry.b0 = bed_pkg::CH_BSLASH;
				end
				bed_pkg::M_PCT: begin
					n_res = 2'd1;
					entry.b0 = bed_pkg::CH_PCT;
				end
				bed_pkg::M_OCT, bed_pkg::M_HEX: begin
					n_res = 2'd1;
					entry.b0 = digit_value_q;
				end
				default: n_res = 2'd0;
			endcase
		end else begin
			unique case (mode_q)
				bed_pkg::M_ESC: begin
					n_res = 2'd1;
					case (ch)
						bed_pkg::CH_DQUOTE, bed_pkg::CH_SQUOTE,
						bed_pkg::CH_BSLASH: entry.b0 = ch;
						bed_pkg::CH_LA: entry.b0 = bed_pkg::BEL_BYTE;
						bed_pkg::CH_LB: entry.b0 = bed_pkg::BS_BYTE;
						bed_pkg::CH_LE: entry.b0 = bed_pkg::ESC_BYTE;
						bed_pkg::CH_LF: entry.b0 = bed_pkg::FF_BYTE;
						bed_pkg::CH_LN: entry.b0 = bed_pkg::LF_BYTE;
						bed_pkg::CH_LR: entry.b0 = bed_pkg::CR_BYTE;
						bed_pkg::CH_LT: entry.b0 = bed_pkg::TAB_BYTE;
						bed_pkg::CH_LV: entry.b0 = bed_pkg::VT_BYTE;
						bed_pkg::CH_LC: begin
							entry.b0 = 8'd0;
							entry.halt = 1'b1;
						end
						bed_pkg::CH_LX: n_res = 2'd0;
						default: begin
							if (bed_pkg::is_oct(ch)) begin
								entry.b0 = {5'd0, ch[2:0]};
								n_res = (bed_pkg::OCT_DIGITS <= 1) ? 2'd1 : 2'd0;
							end else begin
								// unknown escape keeps its backslash
								n_res = 2'd2;
								entry.b0 = bed_pkg::CH_BSLASH;
							end
						end
					endcase
				end
				bed_pkg::M_OCT: begin
					if (bed_pkg::is_oct(ch)) begin
						entry.b0 = oct_val;
						n_res = (int'(cnt_inc) >= bed_pkg::OCT_DIGITS) ? 2'd1 : 2'd0;
					end else begin
						entry.b0 = digit_value_q;
						n_res = bed_pkg::plain_emits(ch) ? 2'd2 : 2'd1;
					end
				end
				bed_pkg::M_HEX: begin
					if (hd.ok) begin
						entry.b0 = hex_val;
						n_res = (int'(cnt_inc) >= bed_pkg::HEX_DIGITS) ? 2'd1 : 2'd0;
					end else begin
						entry.b0 = digit_value_q;
						n_res = bed_pkg::plain_emits(ch) ? 2'd2 : 2'd1;
					end
				end
				bed_pkg::M_PCT: begin
					entry.b0 = bed_pkg::CH_PCT;
					if (ch == bed_pkg::CH_PCT)
						n_res = 2'd1;
					else
						n_res = bed_pkg::plain_emits(ch) ? 2'd2 : 2'd1;
				end
				default: begin
					n_res = bed_pkg::plain_emits(ch) ? 2'd1 : 2'd0;
				end
			endcase
		end
		entry.two = n_res[1];
	end

	assign push = accept && (n_res != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= bed_pkg::M_NORMAL;
			digit_value_q <= 8'd0;
			digit_count_q <= 2'd0;
		end else if (accept) begin
			mode_q <= mode_d;
			digit_value_q <= digit_value_d;
			digit_count_q <= digit_count_d;
		end
	end

endmodule

[sv/bed_queue.sv]
// small queue of decoded entries between front and back
module bed_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bed_pkg::entry_t wr_entry,
	input  logic            pop,
	output bed_pkg::entry_t head,
	output logic            empty,
	output logic            full
);

	bed_pkg::entry_t mem_q [bed_pkg::QDEPTH];
	logic [bed_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [bed_pkg::QCNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == bed_pkg::QCNT_W'(bed_pkg::QDEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

[sv/bed_back.sv]
// back end: unpacks queue entries into single result items behind an output register
module bed_back (
	input  logic            clk,
	input  logic            arst_n,
	input  bed_pkg::entry_t head,
	input  logic            empty,
	output logic            pop,
	output logic            res_valid,
	input  logic            res_stall,
	output logic [7:0]      out_byte,
	output logic            last_of_run,
	output logic            halted
);

	logic       res_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q, halted_q;
	logic       second_q;
	logic [7:0] b1_q;
	logic       load;

	// output slot can take a new item
	assign load = !res_valid_q || !res_stall;
	assign pop  = load && !second_q && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			if (second_q) begin
				res_valid_q <= 1'b1;
				second_q <= 1'b0;
			end else begin
				res_valid_q <= !empty;
				second_q <= !empty && head.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (second_q) begin
				out_byte_q <= b1_q;
				last_q <= 1'b1;
				halted_q <= 1'b0;
			end else begin
				out_byte_q <= head.b0;
				last_q <= !head.two;
				halted_q <= head.halt;
				b1_q <= head.b1;
			end
		end
	end

	assign res_valid   = res_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;
	assign halted      = halted_q;

	a_second_follows_first: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> res_valid_q && !last_q)
		else $error("pending second byte without a first byte shown");

	a_halt_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && halted_q |-> last_q && !second_q)
		else $error("halt item is not the only item of its run");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty && !second_q)
		else $error("queue popped while empty or mid entry");

endmodule

[sv/backslash_escape_decoder_unit.sv]
// top level of the backslash escape decoder
// The decoder takes one format-string byte per cycle while item_stall is low and gives decoded
// bytes one per cycle while res_stall is low, each run of results closed by last_of_run. The
// front end decodes an item in the cycle it is accepted and writes its one or two bytes as one
// entry into a four-entry queue; the back end unpacks entries into a registered output, so an
// item with two results (unknown escapes, digit or percent runs ended by a plain byte) gives
// two bytes in turn. item_stall rises only when the queue is full. Items that give no result do not
// touch the queue. After \c the halt result is given and every later item is accepted and
// dropped until reset.
module backslash_escape_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [7:0] ch,
	input  logic       end_mark,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] out_byte,
	output logic       last_of_run,
	output logic       halted
);

	logic            accept, push, pop, empty, full;
	bed_pkg::entry_t wr_entry, head;

	assign item_stall = full;
	assign accept = item_valid && !full;

	bed_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.ch       (ch),
		.end_mark (end_mark),
		.push     (push),
		.entry    (wr_entry)
	);

	bed_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	bed_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.halted      (halted)
	);

endmodule
